@@ hdl/kappa_eulerian_angle_convert_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the kappa / Eulerian angle converter
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef KAPPA_EULERIAN_ANGLE_CONVERT_TOP_DEFINES_SVH
`define KAPPA_EULERIAN_ANGLE_CONVERT_TOP_DEFINES_SVH

// same-cycle implication
`define KAEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KAEC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kaec_pkg.sv @@
// ----------------------------------------------------------------------------
// kaec_pkg
// Constants, types and helpers of the kappa / Eulerian angle converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kaec_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int W_Z   = 34;
    localparam int W_ROT = 34;
    localparam int W_VEC = 36;
    localparam int W_SQ  = 64;
    localparam int W_RT  = 32;

    localparam int TILT_BITS = 14;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [TILT_BITS-1:0] TILT_RESET = 14'd9102;
    localparam logic                 SEL_RESET  = 1'b1;

    localparam logic signed [W_ROT-1:0] INV_GAIN     = 34'sd652032874;
    localparam logic signed [W_VEC-1:0] NORM_LIMIT   = 36'sd536870912;
    localparam logic [31:0]             QUARTER_TURN = 32'h4000_0000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [0:0] {
        OP_K2E = 1'b0,
        OP_E2K = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TILT = 1'b0,
        CFG_SEL  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    typedef struct packed {
        t_op         op;
        logic        sel;
        logic        reach;
        logic [31:0] va;
        logic [31:0] vc;
    } t_meta;

    typedef struct packed {
        t_meta                  m;
        logic signed [W_ROT-1:0] u;
        logic signed [W_ROT-1:0] v;
        logic signed [W_ROT-1:0] cc;
        logic signed [W_ROT-1:0] sh;
    } t_sq_meta;

    // Q30 product, rounded half up
    function automatic logic signed [W_ROT-1:0] mulq(input logic signed [W_ROT-1:0] a,
                                                     input logic signed [W_ROT-1:0] b);
        logic signed [2*W_ROT-1:0] p;
        p = a * b + 68'sd536870912;
        return W_ROT'(p >>> 30);
    endfunction

endpackage

@@ hdl/kaec_in_if.sv @@
// ----------------------------------------------------------------------------
// kaec_in_if
// Request channel: direction opcode and three input angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kaec_in_if #(
    parameter int ANGLE_BITS = kaec_pkg::ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [ANGLE_BITS-1:0] angle_a;
    logic signed [ANGLE_BITS-1:0] angle_b;
    logic signed [ANGLE_BITS-1:0] angle_c;

    modport source (output valid, opcode, angle_a, angle_b, angle_c, input ready);
    modport sink   (input valid, opcode, angle_a, angle_b, angle_c, output ready);
endinterface

@@ hdl/kaec_out_if.sv @@
// ----------------------------------------------------------------------------
// kaec_out_if
// Result channel: three converted angles and the reachable flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kaec_out_if #(
    parameter int ANGLE_BITS = kaec_pkg::ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
    logic                         reachable;

    modport source (output valid, angle_x, angle_y, angle_z, reachable, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, reachable, output ready);
endinterface

@@ hdl/kappa_eulerian_angle_convert_top.sv @@
// ----------------------------------------------------------------------------
// kappa_eulerian_angle_convert_top
// Converts goniometer angles between kappa (komega, kappa, kphi) and Eulerian
// (omega, chi, phi) form; opcode picks the direction, solution_select the
// mirror solution, tilt_angle the kappa arm tilt. Fully pipelined: one request
// per cycle while the result is not stalled, through the two CORDIC pipelines
// (rotation and vectoring) and the 32-stage square root. A stalled result
// stalls the whole pipeline, input included. Chi beyond twice the tilt returns
// reachable = 0 with all angles zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "kappa_eulerian_angle_convert_top_defines.svh"

module kappa_eulerian_angle_convert_top #(
    parameter int ANGLE_BITS    = kaec_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = kaec_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kaec_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [kaec_pkg::TILT_BITS-1:0]      i_cfg_data,
    kaec_in_if.sink                             i_in,
    kaec_out_if.source                          o_out
);
    import kaec_pkg::*;

    localparam int SH = 32 - ANGLE_BITS;
    localparam int W_META = $bits(t_meta);
    localparam int W_SQM  = $bits(t_sq_meta);

    logic                 en;
    t_pipe_ctl            c_s1, c_m1, c_m2, c_m3, c_vec;

    logic [TILT_BITS-1:0] r_tilt;
    logic                 r_sel;

    // input stage
    logic                 r_s1_vld;
    t_meta                r_s1_meta;
    logic signed [W_Z-1:0] r_s1_half;
    logic signed [W_Z-1:0] r_s1_tilt;
    t_meta                n_s1_meta;
    logic signed [31:0]   vb32;
    logic signed [32:0]   vb33;
    logic [32:0]          mag;

    // sin / cos
    logic                    rot_vld;
    logic signed [W_ROT-1:0] ch, sh, ca, sa;
    logic [W_META-1:0]       rot_meta;

    // products
    logic                    r_m1_vld;
    t_meta                   r_m1_meta;
    logic signed [W_ROT-1:0] r_m1_ch, r_m1_sh, r_m1_u, r_m1_v, r_m1_t1;

    logic                    r_m2_vld;
    t_sq_meta                r_m2_sq;
    logic [W_SQ-1:0]         r_m2_p1, r_m2_p2;
    logic signed [W_ROT-1:0] n_cc;
    logic signed [W_ROT:0]   n_d, n_e;
    logic [W_SQ-1:0]         n_p1, n_p2;
    logic signed [2*W_ROT-1:0] uu;

    logic                    r_m3_vld;
    t_sq_meta                r_m3_sq;
    logic [W_SQ-1:0]         r_m3_s;

    // square root
    logic                    sq_vld;
    logic [W_RT-1:0]         root;
    logic [W_SQM-1:0]        sq_meta_bits;
    t_sq_meta                sq_meta;

    // atan2
    logic signed [W_VEC-1:0] x0, y0, x1, y1;
    logic                    vec_vld;
    logic signed [W_Z-1:0]   ang_p, ang_q;
    logic [W_META-1:0]       vec_meta_bits;
    t_meta                   vm;

    // final combine
    logic [31:0]             p32, q32, rx, ry, rz;
    logic [ANGLE_BITS-1:0]   fx, fy, fz;

    logic                    r_out_vld;
    logic [ANGLE_BITS-1:0]   r_out_x, r_out_y, r_out_z;
    logic                    r_out_reach;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt <= TILT_RESET;
            r_sel  <= SEL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TILT: r_tilt <= i_cfg_data;
                CFG_SEL:  r_sel  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---- input stage ----
    always_comb begin
        vb32 = 32'(i_in.angle_b) <<< SH;
        vb33 = 33'(vb32);
        mag  = (vb33 < 0) ? 33'(-vb33) : 33'(vb33);
        n_s1_meta.op    = t_op'(i_in.opcode);
        n_s1_meta.sel   = r_sel;
        n_s1_meta.reach = (n_s1_meta.op == OP_K2E) || !(mag > 33'({r_tilt, 17'b0}));
        n_s1_meta.va    = 32'(i_in.angle_a) <<< SH;
        n_s1_meta.vc    = 32'(i_in.angle_c) <<< SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_meta <= n_s1_meta;
            r_s1_half <= W_Z'(vb32 >>> 1);
            r_s1_tilt <= W_Z'({r_tilt, 16'b0});
        end
    end

    assign c_s1 = '{en: en, vld: r_s1_vld};

    kaec_cordic_rot #(.STAGES(CORDIC_STAGES), .META_W(W_META)) u_rot_half (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (c_s1),
        .i_z    (r_s1_half),
        .i_meta (r_s1_meta),
        .o_vld  (rot_vld),
        .o_cos  (ch),
        .o_sin  (sh),
        .o_meta (rot_meta)
    );

    kaec_cordic_rot #(.STAGES(CORDIC_STAGES), .META_W(1)) u_rot_tilt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (c_s1),
        .i_z    (r_s1_tilt),
        .i_meta (1'b0),
        .o_vld  (),
        .o_cos  (ca),
        .o_sin  (sa),
        .o_meta ()
    );

    // ---- product stages ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= rot_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_meta <= t_meta'(rot_meta);
            r_m1_ch   <= ch;
            r_m1_sh   <= sh;
            r_m1_u    <= mulq(sh, ca);
            r_m1_v    <= mulq(sh, sa);
            r_m1_t1   <= mulq(sa, ch);
        end
    end

    always_comb begin
        n_cc = (r_m1_ch < 0) ? '0 : r_m1_ch;
        n_d  = (W_ROT+1)'(r_m1_t1) - (W_ROT+1)'(r_m1_u);
        n_e  = (W_ROT+1)'(r_m1_t1) + (W_ROT+1)'(r_m1_u);
        if (n_d < 0) begin
            n_d = '0;
        end
        if (n_e < 0) begin
            n_e = '0;
        end
        uu = r_m1_u * r_m1_u;
        if (r_m1_meta.op == OP_E2K) begin
            n_p1 = W_SQ'(n_d[31:0]) * W_SQ'(n_e[31:0]);
            n_p2 = '0;
        end else begin
            n_p1 = W_SQ'(n_cc[31:0]) * W_SQ'(n_cc[31:0]);
            n_p2 = uu[W_SQ-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_sq.m  <= r_m1_meta;
            r_m2_sq.u  <= r_m1_u;
            r_m2_sq.v  <= r_m1_v;
            r_m2_sq.cc <= n_cc;
            r_m2_sq.sh <= r_m1_sh;
            r_m2_p1    <= n_p1;
            r_m2_p2    <= n_p2;
            r_m3_sq    <= r_m2_sq;
            r_m3_s     <= r_m2_p1 + r_m2_p2;
        end
    end

    assign c_m3 = '{en: en, vld: r_m3_vld};
    assign c_m1 = '{en: en, vld: r_m1_vld};
    assign c_m2 = '{en: en, vld: r_m2_vld};

    kaec_isqrt #(.META_W(W_SQM)) u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (c_m3),
        .i_val  (r_m3_s),
        .i_meta (r_m3_sq),
        .o_vld  (sq_vld),
        .o_root (root),
        .o_meta (sq_meta_bits)
    );

    // ---- atan2 operands ----
    always_comb begin
        sq_meta = t_sq_meta'(sq_meta_bits);
        if (sq_meta.m.op == OP_K2E) begin
            x0 = W_VEC'(sq_meta.cc);
            y0 = W_VEC'(sq_meta.u);
            x1 = W_VEC'({1'b0, root});
            y1 = W_VEC'(sq_meta.v);
        end else begin
            x0 = W_VEC'({1'b0, root});
            y0 = W_VEC'(sq_meta.u);
            x1 = W_VEC'({1'b0, root});
            y1 = W_VEC'(sq_meta.sh);
        end
    end

    assign c_vec = '{en: en, vld: sq_vld};

    kaec_cordic_vec #(.STAGES(CORDIC_STAGES), .META_W(W_META)) u_vec_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (c_vec),
        .i_x    (x0),
        .i_y    (y0),
        .i_meta (sq_meta.m),
        .o_vld  (vec_vld),
        .o_ang  (ang_p),
        .o_meta (vec_meta_bits)
    );

    kaec_cordic_vec #(.STAGES(CORDIC_STAGES), .META_W(1)) u_vec_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (c_vec),
        .i_x    (x1),
        .i_y    (y1),
        .i_meta (1'b0),
        .o_vld  (),
        .o_ang  (ang_q),
        .o_meta ()
    );

    // ---- final combine ----
    always_comb begin
        vm  = t_meta'(vec_meta_bits);
        p32 = ang_p[31:0];
        q32 = ang_q[31:0];
        if (vm.op == OP_K2E) begin
            if (vm.sel) begin
                rx = vm.va + p32 - QUARTER_TURN;
                ry = q32 << 1;
                rz = vm.vc + p32 + QUARTER_TURN;
            end else begin
                rx = vm.va + p32 + QUARTER_TURN;
                ry = 32'(-(q32 << 1));
                rz = vm.vc + p32 - QUARTER_TURN;
            end
        end else begin
            if (vm.sel) begin
                rx = vm.va - p32 + QUARTER_TURN;
                ry = q32 << 1;
                rz = vm.vc - p32 - QUARTER_TURN;
            end else begin
                rx = vm.va + p32 - QUARTER_TURN;
                ry = 32'(-(q32 << 1));
                rz = vm.vc + p32 + QUARTER_TURN;
            end
        end
    end

    if (SH > 0) begin : g_round
        localparam logic [31:0] HALF_LSB = 32'd1 << (SH - 1);
        logic [31:0] tx, ty, tz;
        assign tx = rx + HALF_LSB;
        assign ty = ry + HALF_LSB;
        assign tz = rz + HALF_LSB;
        assign fx = tx[31 -: ANGLE_BITS];
        assign fy = ty[31 -: ANGLE_BITS];
        assign fz = tz[31 -: ANGLE_BITS];
    end else begin : g_full
        assign fx = rx[ANGLE_BITS-1:0];
        assign fy = ry[ANGLE_BITS-1:0];
        assign fz = rz[ANGLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_reach <= vm.reach;
            r_out_x     <= vm.reach ? fx : '0;
            r_out_y     <= vm.reach ? fy : '0;
            r_out_z     <= vm.reach ? fz : '0;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.angle_x   = r_out_x;
    assign o_out.angle_y   = r_out_y;
    assign o_out.angle_z   = r_out_z;
    assign o_out.reachable = r_out_reach;

    `KAEC_ASSERT_IMP(a_unreach_zero, o_out.valid && !o_out.reachable, o_out.angle_x == '0 && o_out.angle_y == '0 && o_out.angle_z == '0, "unreachable result with nonzero angles")
    `KAEC_ASSERT_IMP(a_stall_blocks_in, o_out.valid && !o_out.ready && c_m1.en == en && c_m2.vld == r_m2_vld, !i_in.ready, "request taken while result stalled")
    `KAEC_ASSERT_NXT(a_out_from_pipe, !o_out.valid && !vec_vld, !o_out.valid, "result without a request in the last stage")

endmodule

@@ hdl/kaec_cordic_rot.sv @@
// ----------------------------------------------------------------------------
// kaec_cordic_rot
// Pipelined CORDIC rotation, one micro-rotation per stage: cosine and sine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kaec_cordic_rot #(
    parameter int STAGES = kaec_pkg::CORDIC_STAGES_DEF,
    parameter int META_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kaec_pkg::t_pipe_ctl               i_ctl,
    input  logic signed [kaec_pkg::W_Z-1:0]   i_z,
    input  logic [META_W-1:0]                 i_meta,
    output logic                              o_vld,
    output logic signed [kaec_pkg::W_ROT-1:0] o_cos,
    output logic signed [kaec_pkg::W_ROT-1:0] o_sin,
    output logic [META_W-1:0]                 o_meta
);
    import kaec_pkg::*;

    logic signed [W_ROT-1:0] r_x [STAGES];
    logic signed [W_ROT-1:0] r_y [STAGES];
    logic signed [W_Z-1:0]   r_z [STAGES];
    logic [META_W-1:0]       r_meta [STAGES];
    logic [STAGES-1:0]       r_vld;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [W_ROT-1:0] x_in, y_in, n_x, n_y;
        logic signed [W_Z-1:0]   z_in, n_z, step;
        logic [META_W-1:0]       m_in;
        logic                    v_in;

        if (g == 0) begin : g_first
            assign x_in = INV_GAIN;
            assign y_in = '0;
            assign z_in = i_z;
            assign m_in = i_meta;
            assign v_in = i_ctl.vld;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign m_in = r_meta[g-1];
            assign v_in = r_vld[g-1];
        end

        assign step = W_Z'(ATAN_TAB[g]);

        always_comb begin
            if (z_in >= 0) begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - step;
            end else begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + step;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_z[g]    <= n_z;
                r_meta[g] <= m_in;
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_cos  = r_x[STAGES-1];
    assign o_sin  = r_y[STAGES-1];
    assign o_meta = r_meta[STAGES-1];

endmodule

@@ hdl/kaec_isqrt.sv @@
// ----------------------------------------------------------------------------
// kaec_isqrt
// Pipelined integer square root, one result bit per stage, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kaec_isqrt #(
    parameter int META_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kaec_pkg::t_pipe_ctl          i_ctl,
    input  logic [kaec_pkg::W_SQ-1:0]    i_val,
    input  logic [META_W-1:0]            i_meta,
    output logic                         o_vld,
    output logic [kaec_pkg::W_RT-1:0]    o_root,
    output logic [META_W-1:0]            o_meta
);
    import kaec_pkg::*;

    localparam int W_REM = W_RT + 2;

    logic [W_SQ-1:0]   r_v    [W_RT];
    logic [W_REM-1:0]  r_rem  [W_RT];
    logic [W_RT-1:0]   r_root [W_RT];
    logic [META_W-1:0] r_meta [W_RT];
    logic [W_RT-1:0]   r_vld;

    for (genvar g = 0; g < W_RT; g++) begin : g_stage
        logic [W_SQ-1:0]   v_in;
        logic [W_REM-1:0]  rem_in, n_rem;
        logic [W_RT-1:0]   root_in, n_root;
        logic [W_REM+1:0]  acc, trial;
        logic [META_W-1:0] m_in;
        logic              vd_in;

        if (g == 0) begin : g_first
            assign v_in    = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
            assign m_in    = i_meta;
            assign vd_in   = i_ctl.vld;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign m_in    = r_meta[g-1];
            assign vd_in   = r_vld[g-1];
        end

        always_comb begin
            acc   = {rem_in, v_in[W_SQ-1 -: 2]};
            trial = (W_REM+2)'({root_in, 2'b01});
            if (acc >= trial) begin
                n_rem  = W_REM'(acc - trial);
                n_root = {root_in[W_RT-2:0], 1'b1};
            end else begin
                n_rem  = W_REM'(acc);
                n_root = {root_in[W_RT-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= vd_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_v[g]    <= {v_in[W_SQ-3:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_meta[g] <= m_in;
            end
        end
    end

    assign o_vld  = r_vld[W_RT-1];
    assign o_root = r_root[W_RT-1];
    assign o_meta = r_meta[W_RT-1];

endmodule

@@ hdl/kaec_cordic_vec.sv @@
// ----------------------------------------------------------------------------
// kaec_cordic_vec
// Pipelined atan2: staged normalization, then CORDIC vectoring stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kaec_cordic_vec #(
    parameter int STAGES = kaec_pkg::CORDIC_STAGES_DEF,
    parameter int META_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kaec_pkg::t_pipe_ctl               i_ctl,
    input  logic signed [kaec_pkg::W_VEC-1:0] i_x,
    input  logic signed [kaec_pkg::W_VEC-1:0] i_y,
    input  logic [META_W-1:0]                 i_meta,
    output logic                              o_vld,
    output logic signed [kaec_pkg::W_Z-1:0]   o_ang,
    output logic [META_W-1:0]                 o_meta
);
    import kaec_pkg::*;

    // init, five binary shift steps, final doubling
    localparam int NST = 7;

    logic signed [W_VEC-1:0] r_nx [NST];
    logic signed [W_VEC-1:0] r_ny [NST];
    logic [NST-1:0]          r_nb;
    logic [NST-1:0]          r_nz;
    logic [NST-1:0]          r_nv;
    logic [META_W-1:0]       r_nm [NST];

    logic signed [W_VEC-1:0] r_x [STAGES];
    logic signed [W_VEC-1:0] r_y [STAGES];
    logic signed [W_Z-1:0]   r_z [STAGES];
    logic [STAGES-1:0]       r_zero;
    logic [STAGES-1:0]       r_vld;
    logic [META_W-1:0]       r_meta [STAGES];

    for (genvar g = 0; g < NST; g++) begin : g_norm
        logic signed [W_VEC-1:0] n_x, n_y;
        logic                    n_b, n_z;

        if (g == 0) begin : g_init
            logic signed [W_VEC-1:0] xc;
            assign xc  = (i_x < 0) ? '0 : i_x;
            assign n_x = xc;
            assign n_y = i_y;
            assign n_b = (xc < NORM_LIMIT) && (i_y < NORM_LIMIT) && (i_y > -NORM_LIMIT);
            assign n_z = (xc == '0) && (i_y == '0);
        end else if (g < NST - 1) begin : g_shift
            localparam int SHIFT = 1 << (NST - 2 - g);
            logic signed [W_VEC-1:0] lim;
            logic                    fit;
            assign lim = NORM_LIMIT >>> SHIFT;
            assign fit = r_nb[g-1] && (r_nx[g-1] < lim) && (r_ny[g-1] < lim)
                         && (r_ny[g-1] > -lim);
            assign n_x = fit ? (r_nx[g-1] <<< SHIFT) : r_nx[g-1];
            assign n_y = fit ? (r_ny[g-1] <<< SHIFT) : r_ny[g-1];
            assign n_b = r_nb[g-1];
            assign n_z = r_nz[g-1];
        end else begin : g_last
            assign n_x = r_nb[g-1] ? (r_nx[g-1] <<< 1) : r_nx[g-1];
            assign n_y = r_nb[g-1] ? (r_ny[g-1] <<< 1) : r_ny[g-1];
            assign n_b = r_nb[g-1];
            assign n_z = r_nz[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_nv[g] <= (g == 0) ? i_ctl.vld : r_nv[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_nx[g] <= n_x;
                r_ny[g] <= n_y;
                r_nb[g] <= n_b;
                r_nz[g] <= n_z;
                r_nm[g] <= (g == 0) ? i_meta : r_nm[(g == 0) ? 0 : g-1];
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [W_VEC-1:0] x_in, y_in, n_x, n_y;
        logic signed [W_Z-1:0]   z_in, n_z, step;
        logic [META_W-1:0]       m_in;
        logic                    v_in, zr_in;

        if (g == 0) begin : g_first
            assign x_in  = r_nx[NST-1];
            assign y_in  = r_ny[NST-1];
            assign z_in  = '0;
            assign m_in  = r_nm[NST-1];
            assign v_in  = r_nv[NST-1];
            assign zr_in = r_nz[NST-1];
        end else begin : g_next
            assign x_in  = r_x[g-1];
            assign y_in  = r_y[g-1];
            assign z_in  = r_z[g-1];
            assign m_in  = r_meta[g-1];
            assign v_in  = r_vld[g-1];
            assign zr_in = r_zero[g-1];
        end

        assign step = W_Z'(ATAN_TAB[g]);

        always_comb begin
            if (y_in >= 0) begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + step;
            end else begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - step;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_z[g]    <= n_z;
                r_zero[g] <= zr_in;
                r_meta[g] <= m_in;
            end
        end
    end

    // atan2(0, 0) is defined as 0
    assign o_vld  = r_vld[STAGES-1];
    assign o_ang  = r_zero[STAGES-1] ? '0 : r_z[STAGES-1];
    assign o_meta = r_meta[STAGES-1];

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for kappa_eulerian_angle_convert_top
// Drives direction opcode and angle triples through the request channel under
// random idling and back-pressure. A bit-true fixed-point angle predictor
// (CORDIC, square root, rounding) computes the expected angles and reachable
// flag, which are checked in order. Tilt and solution are reconfigured between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import kaec_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STAGES_DEF + 44;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [15:0] x, y, z;
        logic               reach;
    } t_angles;

    typedef struct {
        t_op                op;
        logic signed [15:0] a, b, c;
        bit                 typed;
        t_angles            res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_idx = CFG_TILT;
    logic [TILT_BITS-1:0] i_cfg_data = '0;

    kaec_in_if  req_if ();
    kaec_out_if res_if ();

    kappa_eulerian_angle_convert_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (res_if)
    );

    always #2 i_clk = ~i_clk;

    logic [TILT_BITS-1:0] tilt_cfg = TILT_RESET;
    logic                 sel_cfg  = SEL_RESET;
    t_angles              angles_due[$];
    int errors = 0, n_k2e = 0, n_e2k = 0, n_unreach = 0, n_results = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    initial begin
        req_if.valid = 1'b0;
        req_if.opcode = 1'b0;
        req_if.angle_a = '0;
        req_if.angle_b = '0;
        req_if.angle_c = '0;
        res_if.ready = 1'b0;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic void cordic_rot(input longint ang, output longint c, output longint s);
        longint x, y, dx, dy;
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x -= dx; y += dy; ang -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; ang += longint'(ATAN_TAB[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint cordic_atan2(input longint x, input longint y);
        longint ang, dx, dy;
        ang = 0;
        if (x < 0) x = 0;
        if (x == 0 && y == 0) return 0;
        while (x < NORM_LIMIT && y < NORM_LIMIT && y > -NORM_LIMIT) begin
            x *= 2;
            y *= 2;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; ang -= longint'(ATAN_TAB[i]);
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_angle(input longint v);
        longint t;
        t = v + 32768;
        return t[31:16];
    endfunction

    function automatic t_angles convert_angles(input t_op op, input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
        t_angles r;
        longint va, vb, vc, tilt, ch, sh, ca, sa, p, q, u, v, cc, mag, t1, t2, d, e, g;
        longint rx, ry, rz, qt;
        longint unsigned m;
        qt = QUARTER_TURN;
        va = longint'(a) <<< 16;
        vb = longint'(b) <<< 16;
        vc = longint'(c) <<< 16;
        tilt = longint'(tilt_cfg) <<< 16;
        cordic_rot(vb >>> 1, ch, sh);
        cordic_rot(tilt, ca, sa);
        if (op == OP_K2E) begin
            u = q30_mul(sh, ca);
            v = q30_mul(sh, sa);
            cc = ch < 0 ? 0 : ch;
            p = cordic_atan2(cc, u);
            m = root_floor(longint'(cc * cc) + longint'(u * u));
            q = cordic_atan2(longint'(m), v);
            if (sel_cfg) begin
                rx = va + p - qt; ry = 2 * q; rz = vc + p + qt;
            end else begin
                rx = va + p + qt; ry = -2 * q; rz = vc + p - qt;
            end
        end else begin
            mag = vb < 0 ? -vb : vb;
            if (mag > 2 * tilt) begin
                r.x = '0; r.y = '0; r.z = '0; r.reach = 1'b0;
                return r;
            end
            t1 = q30_mul(sa, ch);
            t2 = q30_mul(ca, sh);
            d = t1 - t2;
            e = t1 + t2;
            if (d < 0) d = 0;
            if (e < 0) e = 0;
            m = root_floor(longint'(d * e));
            p = cordic_atan2(longint'(m), t2);
            g = cordic_atan2(longint'(m), sh);
            if (sel_cfg) begin
                rx = va - p + qt; ry = 2 * g; rz = vc - p - qt;
            end else begin
                rx = va + p - qt; ry = -2 * g; rz = vc + p + qt;
            end
        end
        r.x = round_angle(rx);
        r.y = round_angle(ry);
        r.z = round_angle(rz);
        r.reach = 1'b1;
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (angles_due.size() == 0) begin
                    report_mismatch("unexpected result, pending", 0, 1);
                end else begin
                    t_angles w;
                    w = angles_due.pop_front();
                    if (res_if.angle_x !== w.x) report_mismatch("angle_x", res_if.angle_x, w.x);
                    if (res_if.angle_y !== w.y) report_mismatch("angle_y", res_if.angle_y, w.y);
                    if (res_if.angle_z !== w.z) report_mismatch("angle_z", res_if.angle_z, w.z);
                    if (res_if.reachable !== w.reach)
                        report_mismatch("reachable", res_if.reachable, w.reach);
                end
            end
            if (!hold_done && n_results == 150) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || ($urandom_range(99) >= 34);
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_request(input t_op op, input logic signed [15:0] a,
                                input logic signed [15:0] b, input logic signed [15:0] c,
                                input bit typed, input t_angles want);
        if (!calm) begin
            while ($urandom_range(99) < 34) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.opcode <= op;
        req_if.angle_a <= a;
        req_if.angle_b <= b;
        req_if.angle_c <= c;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        angles_due.push_back(typed ? want : convert_angles(op, a, b, c));
        if (op == OP_K2E) n_k2e++;
        else n_e2k++;
        if (op == OP_E2K && !(typed ? want.reach : angles_due[$].reach)) n_unreach++;
    endtask

    task automatic drain_pipeline;
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [TILT_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TILT) tilt_cfg = data;
        else sel_cfg = data[0];
    endtask

    task automatic random_requests(input int count);
        t_op op;
        int lim;
        logic signed [15:0] b;
        t_angles none;
        none = '{default: '0};
        for (int k = 0; k < count; k++) begin
            op = t_op'($urandom_range(1));
            lim = 2 * int'(tilt_cfg);
            if (lim > 32767) lim = 32767;
            if (op == OP_E2K && $urandom_range(99) < 70)
                b = 16'($urandom_range(2 * lim) - lim);
            else
                b = 16'($urandom);
            send_request(op, 16'($urandom), b, 16'($urandom), 1'b0, none);
        end
    endtask

    t_row rows[$];
    t_angles zero_res;

    initial begin
        zero_res = '{default: '0};
        rows = '{
            '{OP_K2E, 16'sd0, 16'sd0, 16'sd0, 1'b0, zero_res},
            '{OP_K2E, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, zero_res},
            '{OP_K2E, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, zero_res},
            '{OP_K2E, 16'sd100, 16'sd16384, -16'sd5000, 1'b0, zero_res},
            '{OP_K2E, -16'sd1, -16'sd16384, 16'sd1, 1'b0, zero_res},
            '{OP_K2E, 16'sd12345, 16'sd1, -16'sd12345, 1'b0, zero_res},
            '{OP_E2K, 16'sd0, 16'sd0, 16'sd0, 1'b0, zero_res},
            '{OP_E2K, 16'sd32767, 16'sd18204, -16'sd32768, 1'b0, zero_res},
            '{OP_E2K, -16'sd32768, -16'sd18204, 16'sd32767, 1'b0, zero_res},
            '{OP_E2K, 16'sd500, 16'sd18203, 16'sd500, 1'b0, zero_res},
            '{OP_E2K, 16'sd1, 16'sd18205, 16'sd1, 1'b1, zero_res},
            '{OP_E2K, 16'sd7, -16'sd18205, 16'sd9, 1'b1, zero_res},
            '{OP_E2K, 16'sd1000, -16'sd32768, 16'sd2000, 1'b1, zero_res},
            '{OP_E2K, -16'sd1000, 16'sd32767, -16'sd2000, 1'b1, zero_res},
            '{OP_E2K, 16'sd0, 16'sd9000, 16'sd0, 1'b0, zero_res}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        calm = 1'b1;
        foreach (rows[i])
            send_request(rows[i].op, rows[i].a, rows[i].b, rows[i].c, rows[i].typed,
                         rows[i].res);
        calm = 1'b0;
        random_requests(200);
        drain_pipeline();

        write_reg(CFG_TILT, 14'd16383);
        write_reg(CFG_SEL, 14'd0);
        random_requests(150);
        calm = 1'b1;
        random_requests(60);
        calm = 1'b0;
        drain_pipeline();

        write_reg(CFG_TILT, 14'd1);
        write_reg(CFG_SEL, 14'd1);
        random_requests(100);
        drain_pipeline();

        write_reg(CFG_TILT, 14'd0);
        write_reg(CFG_SEL, 14'd0);
        send_request(OP_E2K, 16'sd300, 16'sd0, -16'sd300, 1'b0, zero_res);
        random_requests(60);
        drain_pipeline();

        write_reg(CFG_TILT, 14'($urandom_range(16383, 1)));
        write_reg(CFG_SEL, 14'($urandom_range(1)));
        random_requests(150);
        drain_pipeline();

        $display("covered %0d kappa-to-Eulerian and %0d Eulerian-to-kappa requests,",
                 n_k2e, n_e2k);
        $display("%0d out of reach, over five tilt/solution settings", n_unreach);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
